@@ rtl/tmsf_pkg.sv @@
// shared types and constants of the trimmed mean sensor filter
package tmsf_pkg;

   localparam int SENSOR_W = 2;
   localparam int ADC_W    = 8;
   localparam int SAMPLE_W = 10;
   localparam int SUM_W    = 16;
   localparam int LOW_KEEP = 2;

   // sample item held in the input register
   typedef struct packed {
      logic                valid;
      logic [SENSOR_W-1:0] sensor;
      logic [SAMPLE_W-1:0] sample;
   } tmsf_smp_type;

   // finished batch waiting for the divide
   typedef struct packed {
      logic                valid;
      logic [SENSOR_W-1:0] sensor;
      logic [SUM_W-1:0]    diff;
   } tmsf_trim_type;

endpackage

@@ rtl/tmsf_accum.sv @@
// per-sensor running min, max, sum and count with the batch-complete register
module tmsf_accum #(
   parameter int NUM_SENSORS = 4,
   parameter int SAMPLES     = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tmsf_pkg::tmsf_smp_type  smp_i,
   output logic                    smp_ready,
   output tmsf_pkg::tmsf_trim_type trim_o,
   input  logic                    trim_ready
);

   localparam int IdxW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int CntW = $clog2(SAMPLES);

   logic [CntW-1:0]              cnt_ff [NUM_SENSORS];
   logic [tmsf_pkg::SAMPLE_W-1:0] min_ff [NUM_SENSORS];
   logic [tmsf_pkg::SAMPLE_W-1:0] max_ff [NUM_SENSORS];
   logic [tmsf_pkg::SUM_W-1:0]    sum_ff [NUM_SENSORS];

   logic [CntW-1:0]               cnt_in;
   logic [tmsf_pkg::SAMPLE_W-1:0] min_in;
   logic [tmsf_pkg::SAMPLE_W-1:0] max_in;
   logic [tmsf_pkg::SUM_W-1:0]    sum_in;

   tmsf_pkg::tmsf_trim_type trim_ff;
   tmsf_pkg::tmsf_trim_type trim_in;

   logic [IdxW-1:0] idx;
   logic            hit;
   logic            first;
   logic            last;
   logic            go;
   logic [CntW-1:0] cur_cnt;

   assign idx       = IdxW'(smp_i.sensor);
   assign hit       = ({3'b000, smp_i.sensor} < 5'(NUM_SENSORS));
   assign smp_ready = !trim_ff.valid || trim_ready;
   assign go        = smp_i.valid && smp_ready && hit;
   assign cur_cnt   = cnt_ff[idx];
   assign first     = (cur_cnt == '0);
   assign last      = (cur_cnt == CntW'(SAMPLES - 1));

   always_comb begin
      if (first) begin
         min_in = smp_i.sample;
         max_in = smp_i.sample;
         sum_in = tmsf_pkg::SUM_W'(smp_i.sample);
      end else begin
         min_in = (smp_i.sample < min_ff[idx]) ? smp_i.sample : min_ff[idx];
         max_in = (smp_i.sample > max_ff[idx]) ? smp_i.sample : max_ff[idx];
         sum_in = sum_ff[idx] + tmsf_pkg::SUM_W'(smp_i.sample);
      end
      cnt_in = last ? '0 : CntW'(cur_cnt + 1'b1);
   end

   always_comb begin
      trim_in = trim_ff;
      if (smp_ready) begin
         trim_in.valid  = go && last;
         trim_in.sensor = smp_i.sensor;
         trim_in.diff   = sum_in - tmsf_pkg::SUM_W'(min_in) - tmsf_pkg::SUM_W'(max_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (go) begin
         cnt_ff[idx] <= cnt_in;
      end
   end

   // stale min, max and sum are overwritten by the first sample of a batch
   always_ff @(posedge clock) begin
      if (go) begin
         min_ff[idx] <= min_in;
         max_ff[idx] <= max_in;
         sum_ff[idx] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff.valid <= 1'b0;
      end else begin
         trim_ff.valid <= trim_in.valid;
      end
      trim_ff.sensor <= trim_in.sensor;
      trim_ff.diff   <= trim_in.diff;
   end

   assign trim_o = trim_ff;

endmodule

@@ rtl/tmsf_div.sv @@
// constant divide by samples minus two via reciprocal multiply, and the result register
module tmsf_div #(
   parameter int SAMPLES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tmsf_pkg::tmsf_trim_type             trim_i,
   output logic                                trim_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tmsf_pkg::SENSOR_W-1:0]       rsp_sensor_out,
   output logic [tmsf_pkg::SAMPLE_W-1:0]       rsp_trimmed_mean
);

   localparam int Div    = SAMPLES - 2;
   localparam int DivSh  = tmsf_pkg::SUM_W + $clog2(Div);
   localparam int MulW   = tmsf_pkg::SUM_W + 1;
   localparam int ProdW  = tmsf_pkg::SUM_W + MulW;
   localparam int DivMulInt = ((2 ** DivSh) + Div - 1) / Div;
   localparam logic [MulW-1:0] DivMul = MulW'(DivMulInt);

   logic                            valid_ff;
   logic                            valid_in;
   logic [tmsf_pkg::SENSOR_W-1:0]   sensor_ff;
   logic [tmsf_pkg::SENSOR_W-1:0]   sensor_in;
   logic [tmsf_pkg::SAMPLE_W-1:0]   mean_ff;
   logic [tmsf_pkg::SAMPLE_W-1:0]   mean_in;
   logic [ProdW-1:0]                prod;

   assign trim_ready = !valid_ff || rsp_ready;
   assign prod       = ProdW'(trim_i.diff) * ProdW'(DivMul);

   always_comb begin
      valid_in  = valid_ff;
      sensor_in = sensor_ff;
      mean_in   = mean_ff;
      if (trim_ready) begin
         valid_in  = trim_i.valid;
         sensor_in = trim_i.sensor;
         mean_in   = prod[DivSh +: tmsf_pkg::SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sensor_ff <= sensor_in;
      mean_ff   <= mean_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sensor_out   = sensor_ff;
   assign rsp_trimmed_mean = mean_ff;

endmodule

@@ rtl/trimmed_mean_sensor_filter.sv @@
// top level of the trimmed mean sensor filter
// usage:
//   req channel carries one left-justified adc conversion per item: sensor number,
//   high result byte and low result byte (only its top two bits count)
//   rsp channel carries one item per completed batch: sensor_out and trimmed_mean,
//   the batch sum less one min and one max, divided by SAMPLES-2, truncated
//   items for a sensor number at or above NUM_SENSORS are dropped
//   path: the item that completes a batch passes the input, batch and result
//   registers in turn before rsp_valid goes high
//   throughput: one item per cycle while no stage stalls; the per-sensor update and
//   the reciprocal multiply each sit in one register stage
//   stall: while rsp_ready is low the result register holds; the stages behind it
//   keep accepting until each is full, then req_ready drops
//   reset: synchronous; clears all sample counts so every sensor starts a new batch
module trimmed_mean_sensor_filter #(
   parameter int NUM_SENSORS = 4,
   parameter int SAMPLES     = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tmsf_pkg::SENSOR_W-1:0]     req_sensor,
   input  logic [tmsf_pkg::ADC_W-1:0]        req_adc_high,
   input  logic [tmsf_pkg::ADC_W-1:0]        req_adc_low,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tmsf_pkg::SENSOR_W-1:0]     rsp_sensor_out,
   output logic [tmsf_pkg::SAMPLE_W-1:0]     rsp_trimmed_mean
);

   tmsf_pkg::tmsf_smp_type  smp_ff;
   tmsf_pkg::tmsf_smp_type  smp_in;
   tmsf_pkg::tmsf_trim_type trim;
   logic                    smp_ready;
   logic                    trim_ready;

   assign req_ready = !smp_ff.valid || smp_ready;

   always_comb begin
      smp_in = smp_ff;
      if (req_ready) begin
         smp_in.valid  = req_valid;
         smp_in.sensor = req_sensor;
         smp_in.sample = {req_adc_high,
                          req_adc_low[tmsf_pkg::ADC_W-1 -: tmsf_pkg::LOW_KEEP]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff.valid <= 1'b0;
      end else begin
         smp_ff.valid <= smp_in.valid;
      end
      smp_ff.sensor <= smp_in.sensor;
      smp_ff.sample <= smp_in.sample;
   end

   tmsf_accum #(
      .NUM_SENSORS (NUM_SENSORS),
      .SAMPLES     (SAMPLES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .smp_i      (smp_ff),
      .smp_ready  (smp_ready),
      .trim_o     (trim),
      .trim_ready (trim_ready)
   );

   tmsf_div #(
      .SAMPLES (SAMPLES)
   ) u_div (
      .clock            (clock),
      .reset            (reset),
      .trim_i           (trim),
      .trim_ready       (trim_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sensor_out   (rsp_sensor_out),
      .rsp_trimmed_mean (rsp_trimmed_mean)
   );

`ifndef SYNTHESIS
   a_sensor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({3'b000, rsp_sensor_out} < 5'(NUM_SENSORS)))
      else $error("result for a sensor outside the configured range");

   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> smp_ff.valid)
      else $error("input stage refused an item while empty");

   a_batch_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(trim.valid) |-> $past(smp_ff.valid))
      else $error("batch result appeared without an item in the input stage");
`endif

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the trimmed mean sensor filter
module tb_top;

   localparam int NUM_SENSORS = 4;
   localparam int SAMPLES     = 8;
   localparam int SENSOR_W    = tmsf_pkg::SENSOR_W;
   localparam int ADC_W       = tmsf_pkg::ADC_W;
   localparam int SAMPLE_W    = tmsf_pkg::SAMPLE_W;
   localparam int SUM_W       = tmsf_pkg::SUM_W;
   localparam int LOW_KEEP    = tmsf_pkg::LOW_KEEP;

   typedef struct {
      logic [SENSOR_W-1:0] sensor;
      logic [SAMPLE_W-1:0] mean;
   } mean_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SENSOR_W-1:0] req_sensor = '0;
   logic [ADC_W-1:0]    req_adc_high = '0;
   logic [ADC_W-1:0]    req_adc_low = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SENSOR_W-1:0] rsp_sensor_out;
   logic [SAMPLE_W-1:0] rsp_trimmed_mean;

   logic [SAMPLE_W-1:0] batch_min [NUM_SENSORS];
   logic [SAMPLE_W-1:0] batch_max [NUM_SENSORS];
   logic [SUM_W-1:0]    batch_sum [NUM_SENSORS];
   int                  batch_count [NUM_SENSORS];
   mean_type            pending_means [$];
   int                  errors = 0;
   bit                  no_idle = 1'b0;

   trimmed_mean_sensor_filter #(
      .NUM_SENSORS (NUM_SENSORS),
      .SAMPLES     (SAMPLES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sensor       (req_sensor),
      .req_adc_high     (req_adc_high),
      .req_adc_low      (req_adc_low),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sensor_out   (rsp_sensor_out),
      .rsp_trimmed_mean (rsp_trimmed_mean)
   );

   always #2 clock = ~clock;

   // running min, max and sum per sensor; a full batch queues its trimmed mean
   function automatic void fold_sample(input logic [SENSOR_W-1:0] s,
                                       input logic [ADC_W-1:0] hi,
                                       input logic [ADC_W-1:0] lo);
      logic [SAMPLE_W-1:0] smp;
      logic [SUM_W-1:0]    diff;
      mean_type            m;
      if (s >= NUM_SENSORS) return;
      smp = {hi, lo[ADC_W-1 -: LOW_KEEP]};
      if (batch_count[s] == 0) begin
         batch_min[s] = smp;
         batch_max[s] = smp;
         batch_sum[s] = SUM_W'(smp);
      end else begin
         if (smp < batch_min[s]) batch_min[s] = smp;
         if (smp > batch_max[s]) batch_max[s] = smp;
         batch_sum[s] = batch_sum[s] + SUM_W'(smp);
      end
      batch_count[s]++;
      if (batch_count[s] == SAMPLES) begin
         diff = batch_sum[s] - SUM_W'(batch_min[s]) - SUM_W'(batch_max[s]);
         m.sensor = s;
         m.mean = SAMPLE_W'(diff / (SAMPLES - 2));
         pending_means.push_back(m);
         batch_count[s] = 0;
         batch_sum[s] = '0;
         batch_min[s] = '0;
         batch_max[s] = '0;
      end
   endfunction

   function automatic logic [ADC_W-1:0] pick_high();
      case ($urandom_range(0, 7))
         0: pick_high = '0;
         1: pick_high = '1;
         default: pick_high = ADC_W'($urandom);
      endcase
   endfunction

   // called at a rising edge; returns at the edge where the item is taken
   task automatic send_item(input logic [SENSOR_W-1:0] s, input logic [ADC_W-1:0] hi,
                            input logic [ADC_W-1:0] lo);
      int gap;
      bit took;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sensor <= s;
      req_adc_high <= hi;
      req_adc_low <= lo;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      fold_sample(s, hi, lo);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      wait (pending_means.size() == 0);
      @(posedge clock);
   endtask

   task automatic test_directed();
      logic [ADC_W-1:0] his [8] = '{8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'hFF, 8'h20, 8'h01};
      logic [ADC_W-1:0] los [8] = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'h00, 8'hC0, 8'h3F, 8'h7F};
      // all-zero and all-max batches interleaved, ignored low bits set
      for (int i = 0; i < SAMPLES; i++) begin
         send_item(2'd0, 8'h00, 8'h3F);
         send_item(2'd3, 8'hFF, 8'hFF);
      end
      // min and max in the middle, every low-bit pattern
      for (int i = 0; i < 8; i++) send_item(2'd2, his[i], los[i]);
   endtask

   task automatic test_random_traffic(input int n);
      for (int i = 0; i < n; i++) begin
         send_item(SENSOR_W'($urandom), pick_high(), ADC_W'($urandom));
         if ($urandom_range(0, 149) == 0) hold_until_drained();
      end
   endtask

   task automatic test_back_to_back(input int n);
      no_idle = 1'b1;
      for (int i = 0; i < n; i++)
         send_item(SENSOR_W'($urandom), pick_high(), ADC_W'($urandom));
      no_idle = 1'b0;
   endtask

   // batches on one sensor with ties and values near the ends of the range
   task automatic test_narrow_range(input int n);
      logic [SENSOR_W-1:0] s;
      logic [ADC_W-1:0]    base;
      for (int i = 0; i < n; i++) begin
         if (i % SAMPLES == 0) begin
            s = SENSOR_W'($urandom);
            base = $urandom_range(0, 1) ? 8'h00 : 8'hFE;
         end
         send_item(s, base + ADC_W'($urandom_range(0, 1)), ADC_W'($urandom));
      end
   endtask

   // result side: one stall drawn per item
   initial begin
      int stall;
      bit took;
      wait (!reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         @(posedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            took = rsp_valid;
            if (!took) @(posedge clock);
         end while (!took);
      end
   end

   always @(negedge clock) begin
      mean_type m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected item sensor_out %0d trimmed_mean %0d", $time,
                     rsp_sensor_out, rsp_trimmed_mean);
            errors++;
         end else begin
            m = pending_means.pop_front();
            if (rsp_sensor_out !== m.sensor) begin
               $display("%0t: sensor_out expected %0d actual %0d", $time, m.sensor,
                        rsp_sensor_out);
               errors++;
            end
            if (rsp_trimmed_mean !== m.mean) begin
               $display("%0t: trimmed_mean expected %0d actual %0d", $time, m.mean,
                        rsp_trimmed_mean);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
         batch_min[k] = '0;
         batch_max[k] = '0;
         batch_sum[k] = '0;
         batch_count[k] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      hold_until_drained();
      test_random_traffic(1100);
      test_back_to_back(400);
      test_narrow_range(376);
      req_valid <= 1'b0;
      wait (pending_means.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_means.size() == 0)
         $display("trimmed_mean_sensor_filter: match");
      else
         $display("trimmed_mean_sensor_filter: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("trimmed_mean_sensor_filter: mismatch");
      $finish;
   end

endmodule
